// ===== sv/assert_macros.svh =====
// assertion macros shared by the pid controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pidaw_pkg.sv =====
// shared types, register codes and q16.16 arithmetic helpers for the pid controller
package pidaw_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic signed [47:0] t_wide;

    // configuration register codes
    typedef enum logic [2:0] {
        CFG_KP   = 3'd0,
        CFG_KI   = 3'd1,
        CFG_KD   = 3'd2,
        CFG_KF   = 3'd3,
        CFG_OMIN = 3'd4,
        CFG_OMAX = 3'd5,
        CFG_IMIN = 3'd6,
        CFG_IMAX = 3'd7
    } t_cfg_idx;

    // register file contents
    typedef struct packed {
        t_q kp;
        t_q ki;
        t_q kd;
        t_q kf;
        t_q omin;
        t_q omax;
        t_q imin;
        t_q imax;
    } t_cfg;

    // per-stage control that travels with an item
    typedef struct packed {
        logic valid;
        logic restart;
    } t_ctl;

    localparam t_q Q_MAX = 32'sh7fff_ffff;
    localparam t_q Q_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] Q_ROUND = 64'sd32768;
    localparam int unsigned Q_FRAC = 16;

    // saturate a wide signed value to 32 bits
    function automatic t_q sat(input t_wide x);
        t_q r;
        if (x > 48'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < 48'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // saturating add and subtract
    function automatic t_q sat_add(input t_q a, input t_q b);
        return sat(48'(a) + 48'(b));
    endfunction

    function automatic t_q sat_sub(input t_q a, input t_q b);
        return sat(48'(a) - 48'(b));
    endfunction

    // q16.16 multiply, round half up, saturate
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + Q_ROUND;
        return sat(p[63:Q_FRAC]);
    endfunction

    // clamp, upper limit tested first
    function automatic t_q clamp(input t_q x, input t_q lo, input t_q hi);
        t_q r;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

// ===== sv/pidaw_err_stage.sv =====
// first stage: error, error pair sum and measurement delta
module pidaw_err_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  pidaw_pkg::t_ctl   i_ctl,
    input  pidaw_pkg::t_q     i_target,
    input  pidaw_pkg::t_q     i_measured,
    output pidaw_pkg::t_ctl   o_ctl,
    output pidaw_pkg::t_q     o_err,
    output pidaw_pkg::t_q     o_esum,
    output pidaw_pkg::t_q     o_dmeas
);

    pidaw_pkg::t_ctl r_ctl;
    pidaw_pkg::t_q   r_err;
    pidaw_pkg::t_q   r_esum;
    pidaw_pkg::t_q   r_dmeas;
    pidaw_pkg::t_q   r_last_err;
    pidaw_pkg::t_q   r_last_meas;
    pidaw_pkg::t_q   n_err;

    // error against the setpoint
    assign n_err = pidaw_pkg::sat_sub(i_target, i_measured);

    // history of error and measurement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_last_meas <= '0;
        end else if (i_en && i_ctl.valid) begin
            if (i_ctl.restart) begin
                r_last_err  <= '0;
                r_last_meas <= '0;
            end else begin
                r_last_err  <= n_err;
                r_last_meas <= i_measured;
            end
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err   <= n_err;
            r_esum  <= pidaw_pkg::sat_add(n_err, r_last_err);
            r_dmeas <= pidaw_pkg::sat_sub(i_measured, r_last_meas);
        end
    end

    assign o_ctl   = r_ctl;
    assign o_err   = r_err;
    assign o_esum  = r_esum;
    assign o_dmeas = r_dmeas;

endmodule

// ===== sv/pidaw_prod_stage.sv =====
// second stage: proportional, integral step and derivative gain products
module pidaw_prod_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  pidaw_pkg::t_cfg   i_cfg,
    input  pidaw_pkg::t_ctl   i_ctl,
    input  pidaw_pkg::t_q     i_err,
    input  pidaw_pkg::t_q     i_esum,
    input  pidaw_pkg::t_q     i_dmeas,
    output pidaw_pkg::t_ctl   o_ctl,
    output pidaw_pkg::t_q     o_prop,
    output pidaw_pkg::t_q     o_istep,
    output pidaw_pkg::t_q     o_dgain
);

    pidaw_pkg::t_ctl r_ctl;
    pidaw_pkg::t_q   r_prop;
    pidaw_pkg::t_q   r_istep;
    pidaw_pkg::t_q   r_dgain;

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // three independent multipliers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prop  <= pidaw_pkg::qmul(i_cfg.kp, i_err);
            r_istep <= pidaw_pkg::qmul(i_cfg.ki, i_esum);
            r_dgain <= pidaw_pkg::qmul(i_cfg.kd, i_dmeas);
        end
    end

    assign o_ctl   = r_ctl;
    assign o_prop  = r_prop;
    assign o_istep = r_istep;
    assign o_dgain = r_dgain;

endmodule

// ===== sv/pidaw_state_stage.sv =====
// third stage: integrator with anti-windup clamp and filtered derivative state
`include "assert_macros.svh"

module pidaw_state_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  pidaw_pkg::t_cfg   i_cfg,
    input  pidaw_pkg::t_ctl   i_ctl,
    input  pidaw_pkg::t_q     i_prop,
    input  pidaw_pkg::t_q     i_istep,
    input  pidaw_pkg::t_q     i_dgain,
    output pidaw_pkg::t_ctl   o_ctl,
    output pidaw_pkg::t_q     o_prop,
    output pidaw_pkg::t_q     o_integ,
    output pidaw_pkg::t_q     o_dstate
);

    pidaw_pkg::t_ctl r_ctl;
    pidaw_pkg::t_q   r_prop;
    pidaw_pkg::t_q   r_integ;
    pidaw_pkg::t_q   r_dstate;
    pidaw_pkg::t_q   n_integ;
    pidaw_pkg::t_q   n_dstate;
    pidaw_pkg::t_q   deriv;

    // integrator update, then clamp
    assign n_integ = pidaw_pkg::clamp(pidaw_pkg::sat_add(r_integ, i_istep),
                                      i_cfg.imin, i_cfg.imax);

    // low-pass derivative on the measurement, sign flipped
    assign deriv    = pidaw_pkg::sat_add(i_dgain, pidaw_pkg::qmul(i_cfg.kf, r_dstate));
    assign n_dstate = pidaw_pkg::sat(-48'(deriv));

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_dstate <= '0;
        end else if (i_en && i_ctl.valid) begin
            if (i_ctl.restart) begin
                r_integ  <= '0;
                r_dstate <= '0;
            end else begin
                r_integ  <= n_integ;
                r_dstate <= n_dstate;
            end
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // proportional term rides along
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prop <= i_prop;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_prop   = r_prop;
    assign o_integ  = r_integ;
    assign o_dstate = r_dstate;

    // integrator stays inside ordered limits after an update
    `ASSERT_NEXT(a_integ_in_limits, i_clk, i_rst_n,
        i_en && i_ctl.valid && !i_ctl.restart && i_cfg.imin <= i_cfg.imax,
        r_integ >= i_cfg.imin && r_integ <= i_cfg.imax, "integrator outside its limits")

    // restart clears both state registers
    `ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n,
        i_en && i_ctl.valid && i_ctl.restart,
        r_integ == '0 && r_dstate == '0, "restart left controller state")

endmodule

// ===== sv/pid_controller_antiwindup.sv =====
// top level of the pid controller with anti-windup integrator and filtered derivative
//
// One sample item enters per clock cycle while the output register is free, and its control output
// appears after it passes the error stage, multiplier stage, state stage and output register.
// The recurrence that sets the per-item figure is the derivative filter: one multiply,
// an add and a negate close on the derivative state register for each item, next to the
// integrator add-and-clamp. The pipeline advances whenever the output register is
// empty or being taken; configuration writes take effect at once and belong only to
// idle periods. A restart item clears all controller state and produces zero.
`include "assert_macros.svh"

module pid_controller_antiwindup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // sample items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_target_value,
    input  logic [31:0] i_measured_value,
    input  logic        i_restart,
    // control output items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_control_out
);

    pidaw_pkg::t_cfg r_cfg;
    pidaw_pkg::t_ctl in_ctl;
    pidaw_pkg::t_ctl s1_ctl;
    pidaw_pkg::t_ctl s2_ctl;
    pidaw_pkg::t_ctl s3_ctl;
    pidaw_pkg::t_q   s1_err;
    pidaw_pkg::t_q   s1_esum;
    pidaw_pkg::t_q   s1_dmeas;
    pidaw_pkg::t_q   s2_prop;
    pidaw_pkg::t_q   s2_istep;
    pidaw_pkg::t_q   s2_dgain;
    pidaw_pkg::t_q   s3_prop;
    pidaw_pkg::t_q   s3_integ;
    pidaw_pkg::t_q   s3_dstate;
    pidaw_pkg::t_q   n_control;
    pidaw_pkg::t_q   r_control;
    logic            r_out_valid;
    logic            r_out_restart;
    logic            en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp   <= '0;
            r_cfg.ki   <= '0;
            r_cfg.kd   <= '0;
            r_cfg.kf   <= '0;
            r_cfg.omin <= pidaw_pkg::Q_MIN;
            r_cfg.omax <= pidaw_pkg::Q_MAX;
            r_cfg.imin <= pidaw_pkg::Q_MIN;
            r_cfg.imax <= pidaw_pkg::Q_MAX;
        end else if (i_cfg_we) begin
            unique case (pidaw_pkg::t_cfg_idx'(i_cfg_index))
                pidaw_pkg::CFG_KP:   r_cfg.kp   <= i_cfg_data;
                pidaw_pkg::CFG_KI:   r_cfg.ki   <= i_cfg_data;
                pidaw_pkg::CFG_KD:   r_cfg.kd   <= i_cfg_data;
                pidaw_pkg::CFG_KF:   r_cfg.kf   <= i_cfg_data;
                pidaw_pkg::CFG_OMIN: r_cfg.omin <= i_cfg_data;
                pidaw_pkg::CFG_OMAX: r_cfg.omax <= i_cfg_data;
                pidaw_pkg::CFG_IMIN: r_cfg.imin <= i_cfg_data;
                pidaw_pkg::CFG_IMAX: r_cfg.imax <= i_cfg_data;
            endcase
        end
    end

    // pipeline moves when the output register is free or being taken
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign in_ctl.valid   = i_in_valid;
    assign in_ctl.restart = i_restart;

    pidaw_err_stage u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (in_ctl),
        .i_target   (i_target_value),
        .i_measured (i_measured_value),
        .o_ctl      (s1_ctl),
        .o_err      (s1_err),
        .o_esum     (s1_esum),
        .o_dmeas    (s1_dmeas)
    );

    pidaw_prod_stage u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_ctl   (s1_ctl),
        .i_err   (s1_err),
        .i_esum  (s1_esum),
        .i_dmeas (s1_dmeas),
        .o_ctl   (s2_ctl),
        .o_prop  (s2_prop),
        .o_istep (s2_istep),
        .o_dgain (s2_dgain)
    );

    pidaw_state_stage u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_ctl    (s2_ctl),
        .i_prop   (s2_prop),
        .i_istep  (s2_istep),
        .i_dgain  (s2_dgain),
        .o_ctl    (s3_ctl),
        .o_prop   (s3_prop),
        .o_integ  (s3_integ),
        .o_dstate (s3_dstate)
    );

    // sum of the three terms, clamped, zero on restart
    always_comb begin
        if (s3_ctl.restart) begin
            n_control = '0;
        end else begin
            n_control = pidaw_pkg::clamp(
                pidaw_pkg::sat(48'(s3_prop) + 48'(s3_integ) + 48'(s3_dstate)),
                r_cfg.omin, r_cfg.omax);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s3_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_control     <= n_control;
            r_out_restart <= s3_ctl.restart;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_control;

    // restart item delivers zero
    `ASSERT_NEXT(a_restart_zero, i_clk, i_rst_n,
        en && s3_ctl.valid && s3_ctl.restart,
        o_out_valid && o_control_out == '0, "restart item did not give zero")

    // a normal result honors ordered output limits
    `ASSERT_SAME(a_out_in_limits, i_clk, i_rst_n,
        o_out_valid && !r_out_restart && r_cfg.omin <= r_cfg.omax,
        $signed(o_control_out) >= r_cfg.omin && $signed(o_control_out) <= r_cfg.omax,
        "control output outside its limits")

endmodule
